### src/blids_pkg.sv
// Shared types and constants for the bounded list block.
// Used by blids_cell, bounded_list_insert_delete_search and blids_checker.
`default_nettype none
package blids_pkg;

  localparam int DEPTH  = 32;
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CW     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int S_TDATA_W = ((WORD_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((POS_W + WORD_W + POS_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_SEARCH = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [IDX_W-1:0]   sel;
    logic [WORD_W-1:0]  data;
  } cell_ctrl_t;

endpackage
`default_nettype wire

### src/blids_cell.sv
// One list slot: holds a word, shifts with its neighbors, registers a compare.
// Depends on blids_pkg.
`default_nettype none
module blids_cell (
  input  wire logic                         clk,
  input  wire logic [blids_pkg::IDX_W-1:0]  idx,
  input  wire blids_pkg::cell_ctrl_t        ctrl,
  input  wire logic [blids_pkg::WORD_W-1:0] prev_data,
  input  wire logic [blids_pkg::WORD_W-1:0] next_data,
  output logic      [blids_pkg::WORD_W-1:0] data,
  output logic                              match
);

  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      blids_pkg::CELL_INSERT: begin
        if (idx == ctrl.sel) begin
          data <= ctrl.data;
        end else if (idx > ctrl.sel) begin
          data <= prev_data;
        end
      end
      blids_pkg::CELL_DELETE: begin
        if (idx >= ctrl.sel) begin
          data <= next_data;
        end
      end
      default: begin
        data <= data;
      end
    endcase
    match <= (data == ctrl.data);
  end

endmodule
`default_nettype wire

### src/bounded_list_insert_delete_search.sv
// Top level of the bounded list: a row of blids_cell slots plus the
// operation sequencer. Depends on blids_pkg and blids_cell.
//
// Holds up to DEPTH signed words in order with a count. Each input word is one
// operation (clear, append, insert, delete, search, read) and yields exactly
// one result word with status, position, read value and the count after the
// operation. An operation passes through three steps: the cycle in which it
// is accepted, one in which every slot registers its compare against the
// operand, and one in which the first match is resolved, the slots shift and
// the result word is loaded. The block takes no new word until the result of
// the last one is loaded. The next operation is accepted in the cycle after
// the result is loaded, even if it has not yet been taken; it then waits in
// its last step until the output register is free. Slot contents are not
// cleared by reset; only slots below the count are ever read.
`default_nettype none
module bounded_list_insert_delete_search (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [31:0] value, [37:32] position, rest zero
  input  wire logic [blids_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] kind
  input  wire logic [blids_pkg::KIND_W-1:0]    s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [5:0] found_position, [37:6] read_value, [43:38] entry_count, rest zero
  output logic      [blids_pkg::M_TDATA_W-1:0] m_tdata,
  // [1:0] status
  output logic      [blids_pkg::STAT_W-1:0]    m_tuser
);

  localparam int DEPTH     = blids_pkg::DEPTH;
  localparam int WORD_W    = blids_pkg::WORD_W;
  localparam int IDX_W     = blids_pkg::IDX_W;
  localparam int CNT_W     = blids_pkg::CNT_W;
  localparam int POS_W     = blids_pkg::POS_W;
  localparam int CW        = blids_pkg::CW;
  localparam int M_TDATA_W = blids_pkg::M_TDATA_W;

  blids_pkg::state_t     state, state_next;
  blids_pkg::kind_t      item_kind;
  logic [WORD_W-1:0]     item_value;
  logic [POS_W-1:0]      item_pos;
  logic [CNT_W-1:0]      count, count_next;
  blids_pkg::cell_ctrl_t ctrl;

  logic [WORD_W-1:0]     cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_match;
  logic [DEPTH-1:0]      mask, lowest;
  logic [IDX_W-1:0]      first_idx;
  logic                  any_match;

  logic                  out_free, fire;
  blids_pkg::status_t    res_status;
  logic [CW-1:0]         res_pos;
  logic [WORD_W-1:0]     res_value;

  logic [CW-1:0]         pos_ext, cnt_ext;
  logic [IDX_W-1:0]      pos_idx;

  // slot row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prev_d, next_d;
    if (i == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_mid_lo
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_hi
      assign next_d = cell_data[i+1];
    end
    blids_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctrl      (ctrl),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blids_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == blids_pkg::S_APPLY) && out_free;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      blids_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = blids_pkg::S_CMP;
        end
      end
      blids_pkg::S_CMP: begin
        state_next = blids_pkg::S_APPLY;
      end
      blids_pkg::S_APPLY: begin
        if (out_free) begin
          state_next = blids_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = blids_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_kind  <= blids_pkg::kind_t'(s_tuser);
      item_value <= s_tdata[WORD_W-1:0];
      item_pos   <= s_tdata[WORD_W +: POS_W];
    end
  end

  // first match among live slots
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      mask[i] = cell_match[i] && (CW'(i) < CW'(count));
    end
  end

  assign lowest    = mask & (~mask + DEPTH'(1));
  assign any_match = |mask;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

  assign pos_ext = CW'(item_pos);
  assign cnt_ext = CW'(count);
  assign pos_idx = IDX_W'(pos_ext - CW'(1));

  always_comb begin
    res_status = blids_pkg::ST_OK;
    res_pos    = '0;
    res_value  = '0;
    count_next = count;
    ctrl.cmd   = blids_pkg::CELL_HOLD;
    ctrl.sel   = '0;
    ctrl.data  = item_value;
    unique case (item_kind)
      blids_pkg::KIND_CLEAR: begin
        count_next = '0;
      end
      blids_pkg::KIND_APPEND: begin
        if (cnt_ext == CW'(DEPTH)) begin
          res_status = blids_pkg::ST_FULL;
        end else begin
          ctrl.cmd   = blids_pkg::CELL_INSERT;
          ctrl.sel   = IDX_W'(count);
          count_next = count + CNT_W'(1);
          res_pos    = cnt_ext + CW'(1);
        end
      end
      blids_pkg::KIND_INSERT: begin
        if (cnt_ext == CW'(DEPTH)) begin
          res_status = blids_pkg::ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CW'(1)) begin
          res_status = blids_pkg::ST_BAD_POS;
        end else begin
          ctrl.cmd   = blids_pkg::CELL_INSERT;
          ctrl.sel   = pos_idx;
          count_next = count + CNT_W'(1);
          res_pos    = pos_ext;
        end
      end
      blids_pkg::KIND_DELETE: begin
        if (!any_match) begin
          res_status = blids_pkg::ST_NOT_FOUND;
        end else begin
          ctrl.cmd   = blids_pkg::CELL_DELETE;
          ctrl.sel   = first_idx;
          count_next = count - CNT_W'(1);
          res_pos    = CW'(first_idx) + CW'(1);
        end
      end
      blids_pkg::KIND_SEARCH: begin
        if (!any_match) begin
          res_status = blids_pkg::ST_NOT_FOUND;
        end else begin
          res_pos = CW'(first_idx) + CW'(1);
        end
      end
      blids_pkg::KIND_READ: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          res_status = blids_pkg::ST_BAD_POS;
        end else begin
          res_value = cell_data[pos_idx];
          res_pos   = pos_ext;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
    if (!fire) begin
      ctrl.cmd = blids_pkg::CELL_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else if (fire) begin
      count    <= count_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= res_status;
      m_tdata <= M_TDATA_W'({POS_W'(count_next), res_value, POS_W'(res_pos)});
    end
  end

endmodule
`default_nettype wire

### src/blids_checker.sv
// Port-level checks for bounded_list_insert_delete_search, bound to the top.
// Depends on blids_pkg.
`default_nettype none
module blids_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [blids_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [blids_pkg::STAT_W-1:0]    m_tuser
);

  // one operation in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a word while one was in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[43:38] <= 6'(blids_pkg::DEPTH))
    else $error("entry count above depth");

  a_fail_no_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != 2'(blids_pkg::ST_OK) |-> m_tdata[5:0] == 6'd0 &&
      m_tdata[37:6] == 32'd0)
    else $error("refused operation reported a position or value");

endmodule

bind bounded_list_insert_delete_search blids_checker u_blids_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for bounded_list_insert_delete_search.
// It drives list operations over the slave stream and checks every result word
// against an in-bench list predictor. Depends on blids_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = blids_pkg::DEPTH;
  localparam int WORD_W    = blids_pkg::WORD_W;
  localparam int KIND_W    = blids_pkg::KIND_W;
  localparam int POS_W     = blids_pkg::POS_W;
  localparam int STAT_W    = blids_pkg::STAT_W;
  localparam int S_TDATA_W = blids_pkg::S_TDATA_W;
  localparam int M_TDATA_W = blids_pkg::M_TDATA_W;

  localparam logic [KIND_W-1:0] KIND_NOP6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_NOP7 = 3'd7;
  localparam int RANDOM_OPS = 1750;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 90;

  typedef enum int {GEN_FILL, GEN_CHURN, GEN_DRAIN} gen_mode_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  pos;
    bit                drain;
  } op_t;

  typedef struct packed {
    blids_pkg::status_t status;
    logic [POS_W-1:0]   fpos;
    logic [WORD_W-1:0]  rval;
    logic [POS_W-1:0]   cnt;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;

  bounded_list_insert_delete_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  op_t ops_q[$];
  list_result_t due_results[$];
  op_t cur_op;
  logic [WORD_W-1:0] list_mem [DEPTH];
  int list_len = 0;
  logic [WORD_W-1:0] value_pool [16];
  int total_ops = 0;
  int n_sent = 0;
  int n_checked = 0;
  int err_count = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 0;

  function automatic int send_idle_pct(int n);
    if (n < total_ops / 3) return 15;
    if (n < 2 * total_ops / 3) return 77;
    return 0;
  endfunction

  function automatic int recv_idle_pct(int n);
    if (n < total_ops / 3) return 77;
    if (n < 2 * total_ops / 3) return 15;
    return 0;
  endfunction

  // index of first entry equal to v, or list_len when absent
  function automatic int find_first(logic [WORD_W-1:0] v);
    for (int k = 0; k < list_len; k++)
      if (list_mem[k] == v) return k;
    return list_len;
  endfunction

  task automatic apply_list_op(input op_t op, output list_result_t r);
    int k;
    r = '0;
    r.status = blids_pkg::ST_OK;
    case (op.kind)
      blids_pkg::KIND_CLEAR: list_len = 0;
      blids_pkg::KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = blids_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = op.value;
          list_len++;
          r.fpos = POS_W'(list_len);
        end
      end
      blids_pkg::KIND_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = blids_pkg::ST_FULL;
        end else if (op.pos == 0 || op.pos > list_len + 1) begin
          r.status = blids_pkg::ST_BAD_POS;
        end else begin
          for (k = list_len; k >= op.pos; k--)
            list_mem[k] = list_mem[k-1];
          list_mem[op.pos-1] = op.value;
          list_len++;
          r.fpos = op.pos;
        end
      end
      blids_pkg::KIND_DELETE: begin
        k = find_first(op.value);
        if (k >= list_len) begin
          r.status = blids_pkg::ST_NOT_FOUND;
        end else begin
          r.fpos = POS_W'(k + 1);
          while (k + 1 < list_len) begin
            list_mem[k] = list_mem[k+1];
            k++;
          end
          list_len--;
        end
      end
      blids_pkg::KIND_SEARCH: begin
        k = find_first(op.value);
        if (k >= list_len) r.status = blids_pkg::ST_NOT_FOUND;
        else r.fpos = POS_W'(k + 1);
      end
      blids_pkg::KIND_READ: begin
        if (op.pos == 0 || op.pos > list_len) begin
          r.status = blids_pkg::ST_BAD_POS;
        end else begin
          r.rval = list_mem[op.pos-1];
          r.fpos = op.pos;
        end
      end
      default: ;
    endcase
    r.cnt = POS_W'(list_len);
    status_hits[r.status]++;
    if (list_len == DEPTH) full_hits++;
  endtask

  task automatic report_mismatch(string what, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: mismatch on word %0d, %s: expected %0h, got %0h",
               $time, n_checked, what, want, got);
  endtask

  task automatic push_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value,
                         logic [POS_W-1:0] pos);
    op_t op;
    op.kind = kind;
    op.value = value;
    op.pos = pos;
    op.drain = 0;
    ops_q.push_back(op);
  endtask

  function automatic op_t rand_op(gen_mode_t mode);
    op_t op;
    int r;
    op.drain = 0;
    r = $urandom_range(0, 99);
    case (mode)
      GEN_FILL:
        op.kind = (r < 50) ? blids_pkg::KIND_APPEND : (r < 80) ? blids_pkg::KIND_INSERT :
                  (r < 90) ? blids_pkg::KIND_READ : (r < 95) ? blids_pkg::KIND_SEARCH :
                  blids_pkg::KIND_DELETE;
      GEN_DRAIN:
        op.kind = (r < 50) ? blids_pkg::KIND_DELETE : (r < 70) ? blids_pkg::KIND_SEARCH :
                  (r < 90) ? blids_pkg::KIND_READ : blids_pkg::KIND_APPEND;
      default:
        op.kind = (r < 3) ? blids_pkg::KIND_CLEAR :
                  KIND_W'($urandom_range(blids_pkg::KIND_APPEND, KIND_NOP7));
    endcase
    op.value = ($urandom_range(0, 99) < 15) ? $urandom : value_pool[$urandom_range(0, 15)];
    op.pos = ($urandom_range(0, 99) < 10) ? POS_W'($urandom_range(0, 63))
                                          : POS_W'($urandom_range(0, DEPTH + 1));
    return op;
  endfunction

  always @(posedge clk) begin : driver
    list_result_t res;
    bit fire;
    bit give;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      fire = s_tvalid && s_tready;
      if (fire) begin
        apply_list_op(cur_op, res);
        due_results.push_back(res);
        n_sent <= n_sent + 1;
      end
      if (!s_tvalid || fire) begin
        give = ops_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct(n_sent);
        // drain point: hold the next word until every result is back
        if (give && ops_q[0].drain && due_results.size() != 0) give = 0;
        if (give) begin
          cur_op = ops_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= S_TDATA_W'({cur_op.pos, cur_op.value});
          s_tuser <= cur_op.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    list_result_t got;
    list_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status = blids_pkg::status_t'(m_tuser);
        got.fpos = m_tdata[5:0];
        got.rval = m_tdata[37:6];
        got.cnt = m_tdata[43:38];
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result word", '0, got.rval);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status) report_mismatch("status", want.status, got.status);
          if (got.fpos !== want.fpos) report_mismatch("found_position", want.fpos, got.fpos);
          if (got.rval !== want.rval) report_mismatch("read_value", want.rval, got.rval);
          if (got.cnt !== want.cnt) report_mismatch("entry_count", want.cnt, got.cnt);
        end
        n_checked <= n_checked + 1;
      end
      // one long hold-off late in the run lets the block back up
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && n_sent >= total_ops * 3 / 4) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(0, 99) >= recv_idle_pct(n_sent);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    op_t op;
    gen_mode_t mode;
    int burst;
    int made;
    int r;
    bit drain_set;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    for (int i = 5; i < 16; i++) value_pool[i] = $urandom;

    push_op(blids_pkg::KIND_CLEAR, 32'h0, 6'd0);
    push_op(blids_pkg::KIND_READ, 32'h0, 6'd1);
    push_op(blids_pkg::KIND_SEARCH, 32'h5, 6'd0);
    push_op(blids_pkg::KIND_DELETE, 32'h5, 6'd0);
    push_op(blids_pkg::KIND_APPEND, 32'h8000_0000, 6'd0);
    push_op(blids_pkg::KIND_APPEND, 32'h7fff_ffff, 6'd0);
    push_op(blids_pkg::KIND_APPEND, 32'hffff_ffff, 6'd0);
    push_op(blids_pkg::KIND_INSERT, 32'h0, 6'd1);
    push_op(blids_pkg::KIND_INSERT, 32'h1234_5678, 6'd0);
    push_op(blids_pkg::KIND_INSERT, 32'h1234_5678, 6'd63);
    push_op(blids_pkg::KIND_INSERT, 32'h5555_5555, 6'd5);
    push_op(blids_pkg::KIND_INSERT, 32'haaaa_aaaa, 6'd3);
    push_op(blids_pkg::KIND_READ, 32'h0, 6'd1);
    push_op(blids_pkg::KIND_READ, 32'h0, 6'd6);
    push_op(blids_pkg::KIND_READ, 32'h0, 6'd7);
    push_op(blids_pkg::KIND_READ, 32'h0, 6'd0);
    push_op(blids_pkg::KIND_SEARCH, 32'h7fff_ffff, 6'd0);
    push_op(blids_pkg::KIND_DELETE, 32'hffff_ffff, 6'd0);
    push_op(blids_pkg::KIND_DELETE, 32'h1234_5678, 6'd0);
    push_op(KIND_NOP6, 32'hffff_ffff, 6'd63);
    push_op(KIND_NOP7, 32'h0, 6'd0);
    push_op(blids_pkg::KIND_CLEAR, 32'h0, 6'd0);
    push_op(blids_pkg::KIND_READ, 32'h0, 6'd1);

    made = 0;
    drain_set = 0;
    while (made < RANDOM_OPS) begin
      r = $urandom_range(0, 99);
      mode = (r < 40) ? GEN_FILL : (r < 75) ? GEN_CHURN : GEN_DRAIN;
      burst = $urandom_range(20, 60);
      if ($urandom_range(0, 4) == 0) begin
        push_op(blids_pkg::KIND_CLEAR, $urandom, POS_W'($urandom_range(0, 63)));
        made++;
      end
      for (int i = 0; i < burst; i++) begin
        op = rand_op(mode);
        if (!drain_set && made >= RANDOM_OPS / 2) begin
          op.drain = 1;
          drain_set = 1;
        end
        ops_q.push_back(op);
        made++;
      end
    end
    total_ops = ops_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (n_sent < total_ops || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d list operations: %0d ok, %0d full, %0d not found, %0d bad position",
             n_sent, status_hits[blids_pkg::ST_OK], status_hits[blids_pkg::ST_FULL],
             status_hits[blids_pkg::ST_NOT_FOUND], status_hits[blids_pkg::ST_BAD_POS]);
    $display("Operations ending on a full list: %0d; mismatches counted: %0d",
             full_hits, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
